@@ hw/rtl/calendar_date_time_adder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Calendar date-time adder: assertion macros
// Concurrent check wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_TIME_ADDER_UNIT_MACROS_SVH
`define CALENDAR_DATE_TIME_ADDER_UNIT_MACROS_SVH
`ifndef SYNTH
// check that is switched off while reset is high
`define CDTA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds across reset
`define CDTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDTA_ASSERT(lbl, clk, rst, prop, msg)
`define CDTA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/cdta_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar date-time adder package
// Shared codes, command and status types and calendar helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdta_pkg;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_ADD  = 1'b1;

   // unit codes
   localparam logic [2:0] UNIT_SEC     = 3'd0;
   localparam logic [2:0] UNIT_MIN     = 3'd1;
   localparam logic [2:0] UNIT_HOUR    = 3'd2;
   localparam logic [2:0] UNIT_DAY     = 3'd3;
   localparam logic [2:0] UNIT_WEEK    = 3'd4;
   localparam logic [2:0] UNIT_MONTH   = 3'd5;
   localparam logic [2:0] UNIT_YEAR    = 3'd6;
   localparam logic [2:0] UNIT_INVALID = 3'd7;

   // calendar limits
   localparam logic [13:0] EPOCH_YEAR     = 14'd1970;
   localparam logic [13:0] LAST_YEAR      = 14'd9999;
   localparam logic [21:0] LAST_EPOCH_DAY = 22'd2932896;
   localparam logic [21:0] LEAPS_BEFORE   = 22'd477;
   localparam logic signed [18:0] MONTH_INDEX_LOW = 19'sd23640;

   // reciprocals for division by a constant
   localparam logic [11:0] RECIP25 = 12'd2622;
   localparam logic [18:0] RECIP12 = 19'd349526;
   localparam logic [22:0] RECIP7  = 23'd4793491;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_MY_PREP,
      OP_MY_MUL,
      OP_MY_APPLY,
      OP_TD_PREP,
      OP_T_NORM,
      OP_CLAMP,
      OP_HMS_STEP,
      OP_YEAR_STEP,
      OP_MONTH_STEP,
      OP_YS_A,
      OP_YS_B,
      OP_FIN_A,
      OP_FIN_B,
      OP_OUT_LOAD
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic t_ok;
      logic z_low;
      logic z_high;
      logic hms_done;
      logic year_ok;
      logic month_ok;
   } status_type;

   // Gregorian leap rule; y/100 through a reciprocal of 25 on y/4
   function automatic logic is_leap(input logic [13:0] y);
      logic [11:0] x;
      logic [23:0] p;
      logic [7:0]  q;
      x = y[13:2];
      p = 24'(x) * 24'(RECIP25);
      q = p[23:16];
      return (y[1:0] == 2'b00) && ((x != 12'(12'(q) * 12'd25)) || (q[1:0] == 2'b00));
   endfunction

   function automatic logic [4:0] month_days(input logic [13:0] y, input logic [3:0] m);
      logic lp;
      lp = is_leap(y);
      case (m) inside
         4'd2:                    month_days = lp ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
         default:                 month_days = 5'd31;
      endcase
   endfunction

   // days before the first of month m in a common year
   function automatic logic [8:0] days_before(input logic [3:0] m);
      case (m)
         4'd2:    days_before = 9'd31;
         4'd3:    days_before = 9'd59;
         4'd4:    days_before = 9'd90;
         4'd5:    days_before = 9'd120;
         4'd6:    days_before = 9'd151;
         4'd7:    days_before = 9'd181;
         4'd8:    days_before = 9'd212;
         4'd9:    days_before = 9'd243;
         4'd10:   days_before = 9'd273;
         4'd11:   days_before = 9'd304;
         4'd12:   days_before = 9'd334;
         default: days_before = 9'd0;
      endcase
   endfunction

   function automatic logic [2:0] quarter_of(input logic [3:0] m);
      case (m) inside
         4'd1, 4'd2, 4'd3: quarter_of = 3'd1;
         4'd4, 4'd5, 4'd6: quarter_of = 3'd2;
         4'd7, 4'd8, 4'd9: quarter_of = 3'd3;
         default:          quarter_of = 3'd4;
      endcase
   endfunction

endpackage

@@ hw/rtl/calendar_date_time_adder_unit.sv @@
// ----------------------------------------------------------------------------
// Calendar date-time adder unit
// Gregorian date-time counter that loads a date-time or adds a signed amount
// in one unit and reports the normalized date with derived calendar fields.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one request: a load of a full date-time, or an
//   add of a signed amount in seconds, minutes, hours, days, weeks, months or
//   years. Every request yields exactly one response on the rsp channel with
//   the date-time after the request, weekday, day of year, quarter, days
//   since 1970-01-01 and the unit and range error flags.
//   A load or an invalid unit runs only the year-start and final steps; a
//   month or year add first runs its prepare, multiply and apply steps.
//   Second to week adds run one day per cycle for the day carry out of the
//   time of day, then split hours, minutes and seconds, walk one year per
//   cycle to find the new year and one month per cycle within it; the worst
//   case is a large hour amount.
//   One request is in flight at a time; a new request is taken while a
//   finished response still waits in the output register.
//   Reset puts the date-time at 1970-01-01 00:00:00 and drops any response.
//   When the receiver stalls, the response holds and the next finished
//   result waits in the controller until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_date_time_adder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // amount[16:0], load_year[30:17], load_month[34:31], load_day[39:35],
   // load_hour[44:40], load_minute[50:45], load_second[56:51], zero fill
   input  logic [63:0] req_tdata,
   // req_type[0], unit_code[3:1]
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cur_year[13:0], cur_month[17:14], cur_day[22:18], cur_hour[27:23],
   // cur_minute[33:28], cur_second[39:34], weekday[42:40],
   // ordinal_day[51:43], quarter[54:52], epoch_days[76:55], zero fill
   output logic [79:0] rsp_tdata,
   // unit_error[0], range_error[1]
   output logic [1:0]  rsp_tuser
);
   import cdta_pkg::*;

   cmd_type    cmd;
   status_type status;

   // unpack the request
   logic               req_type;
   logic [2:0]         unit_code;
   logic signed [16:0] amount;
   logic [13:0]        load_year;
   logic [3:0]         load_month;
   logic [4:0]         load_day;
   logic [4:0]         load_hour;
   logic [5:0]         load_minute;
   logic [5:0]         load_second;

   assign req_type    = req_tuser[0];
   assign unit_code   = req_tuser[3:1];
   assign amount      = $signed(req_tdata[16:0]);
   assign load_year   = req_tdata[30:17];
   assign load_month  = req_tdata[34:31];
   assign load_day    = req_tdata[39:35];
   assign load_hour   = req_tdata[44:40];
   assign load_minute = req_tdata[50:45];
   assign load_second = req_tdata[56:51];

   cdta_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_type),
      .unit_code  (unit_code),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cdta_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_type),
      .unit_code   (unit_code),
      .amount      (amount),
      .load_year   (load_year),
      .load_month  (load_month),
      .load_day    (load_day),
      .load_hour   (load_hour),
      .load_minute (load_minute),
      .load_second (load_second),
      .rsp_data    (rsp_tdata),
      .rsp_flags   (rsp_tuser)
   );

endmodule

@@ hw/rtl/cdta_datapath.sv @@
// ----------------------------------------------------------------------------
// Calendar date-time adder datapath
// Date-time registers, day/second accumulators and the step units that the
// controller drives one operation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdta_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  cdta_pkg::cmd_type    cmd,
   output cdta_pkg::status_type status,
   input  logic                 req_type,
   input  logic [2:0]           unit_code,
   input  logic signed [16:0]   amount,
   input  logic [13:0]          load_year,
   input  logic [3:0]           load_month,
   input  logic [4:0]           load_day,
   input  logic [4:0]           load_hour,
   input  logic [5:0]           load_minute,
   input  logic [5:0]           load_second,
   output logic [79:0]          rsp_data,
   output logic [1:0]           rsp_flags
);
   import cdta_pkg::*;

   // held date-time and year start
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [21:0] ys_ff, ys_in;

   // working registers
   logic signed [16:0] amt_ff, amt_in;
   logic [2:0]         unit_ff, unit_in;
   logic               uerr_ff, uerr_in;
   logic               rerr_ff, rerr_in;
   logic signed [29:0] t_ff, t_in;
   logic signed [23:0] z_ff, z_in;
   logic [8:0]         rem_ff, rem_in;
   logic signed [18:0] mi_ff, mi_in;
   logic [44:0]        prod_ff, prod_in;
   logic [7:0]         c_ff, c_in;
   logic [21:0]        wx_ff, wx_in;
   logic [21:0]        ep_ff, ep_in;
   logic [8:0]         ord_ff, ord_in;
   logic [2:0]         wd_ff, wd_in;
   logic [79:0]        out_data_ff, out_data_in;
   logic [1:0]         out_flags_ff, out_flags_in;

   // helpers
   logic        leap_cur;
   logic [8:0]  ylen_cur, ylen_prev;
   logic [8:0]  ord_cur;
   logic [21:0] epoch_cur;
   logic [16:0] tod_cur;
   logic [13:0] year_prev;
   logic [21:0] ys_next;
   logic        z_lt, z_ge;
   logic [4:0]  ml_cur;
   logic [13:0] ly_sat;
   logic [3:0]  lm_sat;
   logic [4:0]  ld_max;
   logic [14:0] my_q;
   logic signed [18:0] ny_val;
   logic        my_low, my_high, is_month;
   logic [3:0]  nm_val;
   logic [4:0]  nm_len;
   logic [19:0] q7;

   always_comb begin
      leap_cur  = is_leap(year_ff);
      year_prev = year_ff - 14'd1;
      ylen_cur  = 9'd365 + 9'(leap_cur);
      ylen_prev = 9'd365 + 9'(is_leap(year_prev));
      ord_cur   = days_before(month_ff) + 9'(leap_cur && (month_ff > 4'd2)) + 9'(day_ff);
      epoch_cur = ys_ff + 22'(ord_cur) - 22'd1;
      tod_cur   = 17'(hour_ff) * 17'd3600 + 17'(minute_ff) * 17'd60 + 17'(second_ff);
      ys_next   = ys_ff + 22'(ylen_cur);
      z_lt      = z_ff < $signed({2'b00, ys_ff});
      z_ge      = z_ff >= $signed({2'b00, ys_next});
      ml_cur    = month_days(year_ff, month_ff);
      // load saturation
      ly_sat = (load_year < EPOCH_YEAR) ? EPOCH_YEAR
             : ((load_year > LAST_YEAR) ? LAST_YEAR : load_year);
      lm_sat = (load_month == 4'd0) ? 4'd1 : ((load_month > 4'd12) ? 4'd12 : load_month);
      ld_max = month_days(ly_sat, lm_sat);
      // month and year result
      is_month = (unit_ff == UNIT_MONTH);
      my_q     = prod_ff[36:22];
      ny_val   = is_month ? $signed({4'b0000, my_q}) : mi_ff;
      my_low   = is_month ? (mi_ff < MONTH_INDEX_LOW) : (mi_ff < $signed(19'(EPOCH_YEAR)));
      my_high  = ny_val > $signed(19'(LAST_YEAR));
      nm_val   = is_month ? 4'(mi_ff[17:0] - 18'(my_q) * 18'd12 + 18'd1) : month_ff;
      nm_len   = month_days(ny_val[13:0], nm_val);
      q7       = prod_ff[44:25];
   end

   // operation decode
   always_comb begin
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      ys_in        = ys_ff;
      amt_in       = amt_ff;
      unit_in      = unit_ff;
      uerr_in      = uerr_ff;
      rerr_in      = rerr_ff;
      t_in         = t_ff;
      z_in         = z_ff;
      rem_in       = rem_ff;
      mi_in        = mi_ff;
      prod_in      = prod_ff;
      c_in         = c_ff;
      wx_in        = wx_ff;
      ep_in        = ep_ff;
      ord_in       = ord_ff;
      wd_in        = wd_ff;
      out_data_in  = out_data_ff;
      out_flags_in = out_flags_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            amt_in  = amount;
            unit_in = unit_code;
            uerr_in = (req_type == REQ_ADD) && (unit_code == UNIT_INVALID);
            rerr_in = (req_type == REQ_LOAD)
                    && ((load_year < EPOCH_YEAR) || (load_year > LAST_YEAR));
            if (req_type == REQ_LOAD) begin
               year_in   = ly_sat;
               month_in  = lm_sat;
               day_in    = (load_day == 5'd0) ? 5'd1
                         : ((load_day > ld_max) ? ld_max : load_day);
               hour_in   = (load_hour > 5'd23) ? 5'd23 : load_hour;
               minute_in = (load_minute > 6'd59) ? 6'd59 : load_minute;
               second_in = (load_second > 6'd59) ? 6'd59 : load_second;
            end
         end
         OP_MY_PREP: begin
            if (unit_ff == UNIT_MONTH) begin
               mi_in = $signed(19'(year_ff) * 19'd12 + 19'(month_ff) - 19'd1) + 19'(amt_ff);
            end else begin
               mi_in = $signed(19'(year_ff)) + 19'(amt_ff);
            end
         end
         OP_MY_MUL: begin
            prod_in = 45'(mi_ff[17:0]) * 45'(RECIP12);
         end
         OP_MY_APPLY: begin
            if (my_low) begin
               rerr_in   = 1'b1;
               year_in   = EPOCH_YEAR;
               month_in  = 4'd1;
               day_in    = 5'd1;
               hour_in   = 5'd0;
               minute_in = 6'd0;
               second_in = 6'd0;
            end else if (my_high) begin
               rerr_in   = 1'b1;
               year_in   = LAST_YEAR;
               month_in  = 4'd12;
               day_in    = 5'd31;
               hour_in   = 5'd23;
               minute_in = 6'd59;
               second_in = 6'd59;
            end else begin
               year_in  = ny_val[13:0];
               month_in = nm_val;
               day_in   = (day_ff > nm_len) ? nm_len : day_ff;
            end
         end
         OP_TD_PREP: begin
            case (unit_ff)
               UNIT_DAY:  z_in = $signed({2'b00, epoch_cur}) + 24'(amt_ff);
               UNIT_WEEK: z_in = $signed({2'b00, epoch_cur}) + 24'(amt_ff) * 24'sd7;
               default:   z_in = $signed({2'b00, epoch_cur});
            endcase
            case (unit_ff)
               UNIT_SEC:  t_in = $signed({13'd0, tod_cur}) + 30'(amt_ff);
               UNIT_MIN:  t_in = $signed({13'd0, tod_cur}) + 30'(amt_ff) * 30'sd60;
               UNIT_HOUR: t_in = $signed({13'd0, tod_cur}) + 30'(amt_ff) * 30'sd3600;
               default:   t_in = $signed({13'd0, tod_cur});
            endcase
         end
         OP_T_NORM: begin
            // move one whole day between the second and day counts
            if (t_ff < 30'sd0) begin
               t_in = t_ff + 30'sd86400;
               z_in = z_ff - 24'sd1;
            end else if (t_ff >= 30'sd86400) begin
               t_in = t_ff - 30'sd86400;
               z_in = z_ff + 24'sd1;
            end
         end
         OP_CLAMP: begin
            if (z_ff < 24'sd0) begin
               rerr_in   = 1'b1;
               year_in   = EPOCH_YEAR;
               month_in  = 4'd1;
               day_in    = 5'd1;
               hour_in   = 5'd0;
               minute_in = 6'd0;
               second_in = 6'd0;
            end else if (z_ff > $signed({2'b00, LAST_EPOCH_DAY})) begin
               rerr_in   = 1'b1;
               year_in   = LAST_YEAR;
               month_in  = 4'd12;
               day_in    = 5'd31;
               hour_in   = 5'd23;
               minute_in = 6'd59;
               second_in = 6'd59;
            end else begin
               hour_in   = 5'd0;
               minute_in = 6'd0;
               second_in = 6'd0;
            end
         end
         OP_HMS_STEP: begin
            if (t_ff >= 30'sd3600) begin
               t_in    = t_ff - 30'sd3600;
               hour_in = hour_ff + 5'd1;
            end else if (t_ff >= 30'sd60) begin
               t_in      = t_ff - 30'sd60;
               minute_in = minute_ff + 6'd1;
            end else begin
               second_in = 6'(t_ff);
            end
         end
         OP_YEAR_STEP: begin
            if (z_lt) begin
               year_in = year_prev;
               ys_in   = ys_ff - 22'(ylen_prev);
            end else if (z_ge) begin
               year_in = year_ff + 14'd1;
               ys_in   = ys_next;
            end else begin
               rem_in   = 9'(z_ff - $signed({2'b00, ys_ff}));
               month_in = 4'd1;
            end
         end
         OP_MONTH_STEP: begin
            if (rem_ff >= 9'(ml_cur)) begin
               rem_in   = rem_ff - 9'(ml_cur);
               month_in = month_ff + 4'd1;
            end else begin
               day_in = 5'(rem_ff) + 5'd1;
            end
         end
         OP_YS_A: begin
            c_in = 8'((24'(year_prev[13:2]) * 24'(RECIP25)) >> 16);
         end
         OP_YS_B: begin
            ys_in = 22'(year_ff - EPOCH_YEAR) * 22'd365 + 22'(year_prev[13:2])
                  - 22'(c_ff) + 22'(c_ff[7:2]) - LEAPS_BEFORE;
         end
         OP_FIN_A: begin
            ord_in  = ord_cur;
            ep_in   = epoch_cur;
            wx_in   = epoch_cur + 22'd5;
            prod_in = 45'(epoch_cur + 22'd5) * 45'(RECIP7);
         end
         OP_FIN_B: begin
            wd_in = 3'(wx_ff - 22'(q7) * 22'd7);
         end
         OP_OUT_LOAD: begin
            out_data_in  = {3'b000, ep_ff, quarter_of(month_ff), ord_ff, wd_ff, second_ff,
                            minute_ff, hour_ff, day_ff, month_ff, year_ff};
            out_flags_in = {rerr_ff, uerr_ff};
         end
         default: begin
         end
      endcase
   end

   // date-time state
   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= EPOCH_YEAR;
         month_ff  <= 4'd1;
         day_ff    <= 5'd1;
         hour_ff   <= 5'd0;
         minute_ff <= 6'd0;
         second_ff <= 6'd0;
         ys_ff     <= 22'd0;
      end else begin
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         ys_ff     <= ys_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      amt_ff       <= amt_in;
      unit_ff      <= unit_in;
      uerr_ff      <= uerr_in;
      rerr_ff      <= rerr_in;
      t_ff         <= t_in;
      z_ff         <= z_in;
      rem_ff       <= rem_in;
      mi_ff        <= mi_in;
      prod_ff      <= prod_in;
      c_ff         <= c_in;
      wx_ff        <= wx_in;
      ep_ff        <= ep_in;
      ord_ff       <= ord_in;
      wd_ff        <= wd_in;
      out_data_ff  <= out_data_in;
      out_flags_ff <= out_flags_in;
   end

   // status toward the controller
   always_comb begin
      status.t_ok     = (t_ff >= 30'sd0) && (t_ff < 30'sd86400);
      status.z_low    = z_ff < 24'sd0;
      status.z_high   = z_ff > $signed({2'b00, LAST_EPOCH_DAY});
      status.hms_done = t_ff < 30'sd60;
      status.year_ok  = !z_lt && !z_ge;
      status.month_ok = rem_ff < 9'(ml_cur);
   end

   assign rsp_data  = out_data_ff;
   assign rsp_flags = out_flags_ff;

endmodule

@@ hw/rtl/cdta_controller.sv @@
// ----------------------------------------------------------------------------
// Calendar date-time adder controller
// Sequences the datapath through load, add, normalize and report steps and
// owns the request and response handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "calendar_date_time_adder_unit_macros.svh"

module cdta_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_type,
   input  logic [2:0]           unit_code,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output cdta_pkg::cmd_type    cmd,
   input  cdta_pkg::status_type status
);
   import cdta_pkg::*;

   typedef enum logic [14:0] {
      ST_IDLE       = 15'b000000000000001,
      ST_MY_PREP    = 15'b000000000000010,
      ST_MY_MUL     = 15'b000000000000100,
      ST_MY_APPLY   = 15'b000000000001000,
      ST_TD_PREP    = 15'b000000000010000,
      ST_T_NORM     = 15'b000000000100000,
      ST_CLAMP      = 15'b000000001000000,
      ST_HMS        = 15'b000000010000000,
      ST_YEAR_WALK  = 15'b000000100000000,
      ST_MONTH_WALK = 15'b000001000000000,
      ST_YS_A       = 15'b000010000000000,
      ST_YS_B       = 15'b000100000000000,
      ST_FIN_A      = 15'b001000000000000,
      ST_FIN_B      = 15'b010000000000000,
      ST_DONE       = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and command
   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_CAPTURE;
               if ((req_type == REQ_LOAD) || (unit_code == UNIT_INVALID)) begin
                  state_in = ST_YS_A;
               end else if ((unit_code == UNIT_MONTH) || (unit_code == UNIT_YEAR)) begin
                  state_in = ST_MY_PREP;
               end else begin
                  state_in = ST_TD_PREP;
               end
            end
         end
         ST_MY_PREP: begin
            cmd.op   = OP_MY_PREP;
            state_in = ST_MY_MUL;
         end
         ST_MY_MUL: begin
            cmd.op   = OP_MY_MUL;
            state_in = ST_MY_APPLY;
         end
         ST_MY_APPLY: begin
            cmd.op   = OP_MY_APPLY;
            state_in = ST_YS_A;
         end
         ST_TD_PREP: begin
            cmd.op   = OP_TD_PREP;
            state_in = ST_T_NORM;
         end
         ST_T_NORM: begin
            cmd.op = OP_T_NORM;
            if (status.t_ok) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.op   = OP_CLAMP;
            state_in = (status.z_low || status.z_high) ? ST_YS_A : ST_HMS;
         end
         ST_HMS: begin
            cmd.op = OP_HMS_STEP;
            if (status.hms_done) begin
               state_in = ST_YEAR_WALK;
            end
         end
         ST_YEAR_WALK: begin
            cmd.op = OP_YEAR_STEP;
            if (status.year_ok) begin
               state_in = ST_MONTH_WALK;
            end
         end
         ST_MONTH_WALK: begin
            cmd.op = OP_MONTH_STEP;
            if (status.month_ok) begin
               state_in = ST_FIN_A;
            end
         end
         ST_YS_A: begin
            cmd.op   = OP_YS_A;
            state_in = ST_YS_B;
         end
         ST_YS_B: begin
            cmd.op   = OP_YS_B;
            state_in = ST_FIN_A;
         end
         ST_FIN_A: begin
            cmd.op   = OP_FIN_A;
            state_in = ST_FIN_B;
         end
         ST_FIN_B: begin
            cmd.op   = OP_FIN_B;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = OP_OUT_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the response until it is taken
   always_comb begin
      if (cmd.op == OP_OUT_LOAD) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `CDTA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE) && !rsp_valid_ff, "reset did not return to idle")
   `CDTA_ASSERT(a_accept_leaves_idle, clock, reset, (req_tvalid && req_tready) |=> (state_ff != ST_IDLE), "accepted request left controller idle")
   `CDTA_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "response raised outside done state")
   `CDTA_ASSERT(a_done_waits, clock, reset, (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_DONE), "result overwrote a stalled response")

endmodule

@@ sim/calendar_date_time_adder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Calendar date-time adder unit testbench
// Drives load and add requests over the req stream and checks every response
// against an in-bench calendar predictor, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_date_time_adder_unit_tb;
   import cdta_pkg::*;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
      logic [8:0]  ordinal;
      logic [2:0]  quarter;
      logic [21:0] epoch;
      logic        unit_err;
      logic        range_err;
   } date_rsp_type;

   localparam longint SECS_PER_DAY = 86400;
   localparam longint LAST_DAY_NUM = 2932896;
   localparam longint LAST_SECOND  = (LAST_DAY_NUM + 1) * SECS_PER_DAY - 1;
   localparam longint CYCLE_LIMIT  = 1500000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [3:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // predictor state
   int unsigned  cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second;
   date_rsp_type expected_dates[$];
   int           error_count;
   longint       cycle_count;
   bit           idle_enable;
   int           hold_off_cycles;

   calendar_date_time_adder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
      case (m)
         2:          return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   // civil date to days since 1970-01-01
   function automatic longint day_number(int unsigned y, int unsigned m, int unsigned d);
      longint yy, era, yoe, mp, doy, doe;
      yy  = longint'(y) - ((m <= 2) ? 1 : 0);
      era = yy / 400;
      yoe = yy - era * 400;
      mp  = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mp + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   // set the held date-time from an absolute second count
   function automatic void set_from_seconds(longint s);
      longint z, r, zz, era, doe, yoe, doy, mp, m;
      z   = s / SECS_PER_DAY;
      r   = s - z * SECS_PER_DAY;
      zz  = z + 719468;
      era = zz / 146097;
      doe = zz - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      cal_day    = 32'(doy - (153 * mp + 2) / 5 + 1);
      m          = (mp < 10) ? mp + 3 : mp - 9;
      cal_month  = 32'(m);
      cal_year   = 32'(yoe + era * 400 + ((m <= 2) ? 1 : 0));
      cal_hour   = 32'(r / 3600);
      cal_minute = 32'((r / 60) % 60);
      cal_second = 32'(r % 60);
   endfunction

   function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // advance the held date-time by one request and return the response
   function automatic date_rsp_type predict_date(logic kind, logic [2:0] unit_code,
                                                 logic [63:0] data);
      date_rsp_type r;
      longint       amount, s, ny, nm, mi;
      longint       scale;
      int unsigned  zy, zm, j, k;
      amount = longint'($signed(data[16:0]));
      r.unit_err  = 1'b0;
      r.range_err = 1'b0;
      if (kind == REQ_LOAD) begin
         if (data[30:17] < 1970 || data[30:17] > 9999) r.range_err = 1'b1;
         cal_year   = clip(data[30:17], 1970, 9999);
         cal_month  = clip(data[34:31], 1, 12);
         cal_day    = clip(data[39:35], 1, days_in_month(cal_year, cal_month));
         cal_hour   = clip(data[44:40], 0, 23);
         cal_minute = clip(data[50:45], 0, 59);
         cal_second = clip(data[56:51], 0, 59);
      end else if (unit_code == UNIT_INVALID) begin
         r.unit_err = 1'b1;
      end else if (unit_code <= UNIT_WEEK) begin
         case (unit_code)
            UNIT_SEC:  scale = 1;
            UNIT_MIN:  scale = 60;
            UNIT_HOUR: scale = 3600;
            UNIT_DAY:  scale = SECS_PER_DAY;
            default:   scale = 7 * SECS_PER_DAY;
         endcase
         s = day_number(cal_year, cal_month, cal_day) * SECS_PER_DAY
             + cal_hour * 3600 + cal_minute * 60 + cal_second + amount * scale;
         if (s < 0) begin
            s = 0;
            r.range_err = 1'b1;
         end
         if (s > LAST_SECOND) begin
            s = LAST_SECOND;
            r.range_err = 1'b1;
         end
         set_from_seconds(s);
      end else begin
         if (unit_code == UNIT_MONTH) begin
            mi = longint'(cal_year) * 12 + cal_month - 1 + amount;
            ny = mi / 12;
            nm = mi - ny * 12 + 1;
         end else begin
            ny = longint'(cal_year) + amount;
            nm = cal_month;
         end
         if (ny < 1970) begin
            set_from_seconds(0);
            r.range_err = 1'b1;
         end else if (ny > 9999) begin
            set_from_seconds(LAST_SECOND);
            r.range_err = 1'b1;
         end else begin
            cal_year  = 32'(ny);
            cal_month = 32'(nm);
            cal_day   = clip(cal_day, 1, days_in_month(cal_year, cal_month));
         end
      end
      // derived calendar fields
      zy = cal_year;
      zm = cal_month;
      if (zm <= 2) begin
         zm += 12;
         zy -= 1;
      end
      j = zy / 100;
      k = zy % 100;
      r.year    = 14'(cal_year);
      r.month   = 4'(cal_month);
      r.day     = 5'(cal_day);
      r.hour    = 5'(cal_hour);
      r.minute  = 6'(cal_minute);
      r.second  = 6'(cal_second);
      r.weekday = 3'((cal_day + 13 * (zm + 1) / 5 + k + k / 4 + j / 4 + 5 * j) % 7);
      r.ordinal = 9'(cal_day);
      for (int i = 1; i < cal_month; i++) r.ordinal += 9'(days_in_month(cal_year, i));
      r.quarter = 3'((cal_month - 1) / 3 + 1);
      r.epoch   = 22'(day_number(cal_year, cal_month, cal_day));
      return r;
   endfunction

   function automatic logic [63:0] pack_request(int amount, int y, int mo, int d,
                                                int h, int mi, int s);
      logic [63:0] v;
      v = '0;
      v[16:0]  = amount[16:0];
      v[30:17] = y[13:0];
      v[34:31] = mo[3:0];
      v[39:35] = d[4:0];
      v[44:40] = h[4:0];
      v[50:45] = mi[5:0];
      v[56:51] = s[5:0];
      return v;
   endfunction

   // offer one request, record its prediction once accepted
   task automatic send_request(logic kind, logic [2:0] unit_code, logic [63:0] data);
      while (idle_enable && $urandom_range(99) < 36) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tuser  = {unit_code, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_dates.push_back(predict_date(kind, unit_code, data));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_load(int y, int mo, int d, int h, int mi, int s);
      send_request(REQ_LOAD, 3'($urandom), pack_request($urandom, y, mo, d, h, mi, s));
   endtask

   task automatic send_add(logic [2:0] unit_code, int amount);
      send_request(REQ_ADD, unit_code, pack_request(amount, $urandom, $urandom, $urandom,
                                                    $urandom, $urandom, $urandom));
   endtask

   task automatic wait_drained();
      while (expected_dates.size() != 0) @(negedge clock);
   endtask

   // loads at the field extremes, saturated fields
   task automatic test_load_extremes();
      send_load(1970, 1, 1, 0, 0, 0);
      send_load(9999, 12, 31, 23, 59, 59);
      send_load(16383, 15, 31, 31, 63, 63);
      send_load(0, 0, 0, 0, 0, 0);
      send_load(2000, 2, 31, 12, 30, 30);
      send_load(2100, 2, 29, 1, 2, 3);
   endtask

   // every unit including carries, borrows, clamps and saturation
   task automatic test_unit_adds();
      send_load(2024, 1, 31, 23, 59, 59);
      send_add(UNIT_SEC, 1);
      send_add(UNIT_MONTH, 1);
      send_add(UNIT_MIN, -1);
      send_add(UNIT_HOUR, 65535);
      send_add(UNIT_DAY, -65536);
      send_add(UNIT_WEEK, 5000);
      send_add(UNIT_YEAR, 65535);
      send_add(UNIT_INVALID, 7);
      send_add(UNIT_SEC, 1);
      send_add(UNIT_MONTH, -65536);
      send_add(UNIT_SEC, -1);
      send_add(UNIT_YEAR, -1);
      send_load(1999, 12, 31, 0, 0, 0);
      send_add(UNIT_MONTH, 14);
      send_add(UNIT_WEEK, -65536);
   endtask

   // receiver holds off while requests keep coming, then drain fully
   task automatic test_backpressure();
      hold_off_cycles = 300;
      for (int i = 0; i < 6; i++) send_add(UNIT_DAY, $urandom_range(40) - 20);
      wait_drained();
   endtask

   task automatic test_random_mix(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         idle_enable = !(i >= 40 && i < 70);
         pick = $urandom_range(99);
         if (pick < 15)
            send_load($urandom_range(9999, 1970), $urandom_range(12, 1),
                      $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                      $urandom_range(59));
         else if (pick < 20)
            send_request(REQ_LOAD, 3'($urandom), 64'($urandom) | (64'($urandom) << 32));
         else if (pick < 90)
            // mostly modest amounts, so the slow paths stay bounded
            send_add(3'($urandom_range(6)), $urandom_range(4000) - 2000);
         else
            send_add(3'($urandom), $signed(17'($urandom)));
      end
      idle_enable = 1'b1;
   endtask

   // receiver: random stalls, plus a counted hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles = hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_enable && $urandom_range(99) < 36);
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      date_rsp_type e;
      date_rsp_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.year      = rsp_tdata[13:0];
         a.month     = rsp_tdata[17:14];
         a.day       = rsp_tdata[22:18];
         a.hour      = rsp_tdata[27:23];
         a.minute    = rsp_tdata[33:28];
         a.second    = rsp_tdata[39:34];
         a.weekday   = rsp_tdata[42:40];
         a.ordinal   = rsp_tdata[51:43];
         a.quarter   = rsp_tdata[54:52];
         a.epoch     = rsp_tdata[76:55];
         a.unit_err  = rsp_tuser[0];
         a.range_err = rsp_tuser[1];
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected response %p", $realtime, a);
            error_count++;
         end else begin
            e = expected_dates.pop_front();
            if (a != e) begin
               $display("%0t: mismatch expected %p actual %p", $realtime, e, a);
               error_count++;
            end
         end
      end
   end

   // hard stop
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("calendar_date_time_adder_unit regression: fail");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      error_count     = 0;
      cycle_count     = 0;
      idle_enable     = 1'b1;
      hold_off_cycles = 0;
      cal_year   = 1970;
      cal_month  = 1;
      cal_day    = 1;
      cal_hour   = 0;
      cal_minute = 0;
      cal_second = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_extremes();
      test_unit_adds();
      test_backpressure();
      test_random_mix(115);
      wait_drained();
      repeat (100) @(negedge clock);
      if (error_count == 0 && expected_dates.size() == 0)
         $display("calendar_date_time_adder_unit regression: pass");
      else
         $display("calendar_date_time_adder_unit regression: fail");
      $finish;
   end

endmodule
